### sv/iff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types and constants of the integer field formatter.
// ----------------------------------------------------------------------------
package iff_pkg;

  localparam logic [2:0] CONV_SDEC  = 3'd0;
  localparam logic [2:0] CONV_UDEC  = 3'd1;
  localparam logic [2:0] CONV_OCT   = 3'd2;
  localparam logic [2:0] CONV_HEXL  = 3'd3;
  localparam logic [2:0] CONV_HEXU  = 3'd4;
  localparam logic [2:0] CONV_PTR   = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  // One input word.
  typedef struct packed {
    logic [63:0] magnitude;
    logic        is_negative;
    logic [2:0]  conversion;
    logic        plus_flag;
    logic        space_flag;
    logic        alternate_flag;
    logic        zero_flag;
    logic        left_flag;
    logic [6:0]  field_width;
    logic [6:0]  min_digits;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture request
    logic div_step;  // produce one digit
    logic plan;      // compute field layout
    logic emit;      // advance one character
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_done;
    logic empty;     // field has no characters
    logic emit_last; // current character is the final one
  } sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'd0, d};
    else if (upper) c = 8'h37 + {4'd0, d};
    else c = 8'h57 + {4'd0, d};
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/iff_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface iff_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/integer_field_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_field_formatter
// Turns one integer conversion request into the characters of its field.
// ----------------------------------------------------------------------------
// Usage:
//   req  : sink channel, one conversion request per word.
//   rsp  : source channel, one character per word, last_char on the final one.
// A request is taken only while the block is idle. Octal and hex digits are
// generated one per cycle; a decimal digit is built in steps (a shift-and-add
// estimate of the quotient by ten, then a corrected remainder). The digit
// count is at most 20 decimal, 22 octal or 16 hex. After the digits the
// layout is planned, then the first character can be taken, then one
// character per cycle while the receiver is ready. A field that is empty and
// has zero width yields no words, and the block then returns to idle, where
// the next request can be taken.
// Fields longer than MAX_CHARS are cut off after MAX_CHARS characters.
// When the receiver stalls, the current character is held on the port.
// Reset returns the sequencer to idle; no request is in flight afterward.
// ----------------------------------------------------------------------------
module integer_field_formatter #(
  parameter int unsigned MAX_CHARS = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  iff_stream_if.sink   req,
  iff_stream_if.source rsp
);
  iff_pkg::cmd_t cmd;
  iff_pkg::sts_t sts;

  iff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  iff_datapath #(.MAX_CHARS(MAX_CHARS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req.data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp.data)
  );
endmodule
`default_nettype wire

### sv/iff_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_ctrl
// Sequencer: load, digit generation, layout, character emission.
// ----------------------------------------------------------------------------
module iff_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output iff_pkg::cmd_t      cmd_o,
  input  wire iff_pkg::sts_t sts_i
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PLAN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_PLAN;
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.empty) begin
          state_d = S_IDLE;
        end else begin
          out_valid_o = 1'b1;
          if (out_ready_i) begin
            cmd_o.emit = 1'b1;
            if (sts_i.emit_last) state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("accept while emitting");
  a_div_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.plan |=> (state_q == S_EMIT)) else $error("plan not followed by emit");
  a_load_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.div_step) else $error("load not followed by digits");
endmodule
`default_nettype wire

### sv/iff_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_datapath
// Digit generator and field character sequencer.
// ----------------------------------------------------------------------------
module iff_datapath #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire iff_pkg::req_t req_i,
  input  wire iff_pkg::cmd_t cmd_i,
  output iff_pkg::sts_t      sts_o,
  output iff_pkg::rsp_t      rsp_o
);
  localparam int unsigned CW = $clog2(MAX_CHARS + 1);

  iff_pkg::req_t req_q;
  logic [63:0]   v_q;
  logic [6:0]    n_q;        // digits generated
  logic [2:0]    conv_q;
  logic          sign_q;     // sign char present
  logic [7:0]    sign_ch_q;
  logic [1:0]    pfx_q;      // prefix length beyond sign (0..2)
  logic [7:0]    pfx1_ch_q;
  logic [6:0]    nd_q;       // digits shown
  logic [6:0]    zf_q;       // precision zero fill (incl. octal 0)
  logic [7:0]    fl_q;
  logic [7:0]    pad_q;
  logic [7:0]    pos_q;      // character index
  logic [CW-1:0] k_q;        // characters emitted
  logic          div_done;

  // Digit codes, least significant first, 4 bits each. A 64-bit octal value
  // has up to 22 digits.
  logic [87:0] revd_q;

  // Octal and hex digits take one step. A decimal digit takes four: three
  // steps build a shift-and-add estimate of v / 10 that is at most one low,
  // and the last step forms the remainder and corrects the estimate.
  logic [1:0]  ph_q;
  logic [63:0] t_q;
  logic [63:0] a0, a1, b0, b1, c0;
  logic [63:0] r0;
  logic [4:0]  r5;
  logic        is_dec;
  logic        commit;
  logic [63:0] quo;
  logic [3:0]  rem;
  always_comb begin
    a0 = (v_q >> 1) + (v_q >> 2);
    a1 = a0 + (a0 >> 4);
    b0 = t_q + (t_q >> 8);
    b1 = b0 + (b0 >> 16);
    c0 = (t_q + (t_q >> 32)) >> 3;
    r0 = v_q - ((t_q << 3) + (t_q << 1));
    r5 = r0[4:0];
    case (conv_q)
      iff_pkg::CONV_OCT: begin
        quo = v_q >> 3;
        rem = {1'b0, v_q[2:0]};
      end
      iff_pkg::CONV_HEXL, iff_pkg::CONV_HEXU, iff_pkg::CONV_PTR: begin
        quo = v_q >> 4;
        rem = v_q[3:0];
      end
      default: begin
        if (r5 >= 5'd10) begin
          quo = t_q + 64'd1;
          rem = 4'(r5 - 5'd10);
        end else begin
          quo = t_q;
          rem = r5[3:0];
        end
      end
    endcase
  end

  assign is_dec   = !(conv_q == iff_pkg::CONV_OCT || conv_q == iff_pkg::CONV_HEXL ||
                      conv_q == iff_pkg::CONV_HEXU || conv_q == iff_pkg::CONV_PTR);
  assign commit   = !is_dec || (ph_q == 2'd3);
  assign div_done = commit && ((quo == 64'd0) || (n_q == 7'd63));

  // Layout computed combinationally from captured request.
  logic        upper;
  logic [6:0]  prec;
  logic        has_prec;
  logic        mag_zero;
  logic [6:0]  nd;
  logic [6:0]  zf;
  logic        oct0;
  logic        sgn;
  logic [7:0]  sgn_ch;
  logic [1:0]  pfx;
  logic [7:0]  fl;
  logic [3:0]  top_dig;
  always_comb begin
    upper    = (conv_q == iff_pkg::CONV_HEXU);
    has_prec = !req_q.min_digits[6];
    prec     = has_prec ? req_q.min_digits : 7'd0;
    mag_zero = (req_q.magnitude == 64'd0);
    nd       = (has_prec && prec == 7'd0 && mag_zero && conv_q != iff_pkg::CONV_PTR)
               ? 7'd0 : n_q;
    zf       = (has_prec && prec > nd) ? prec - nd : 7'd0;
    top_dig  = revd_q[4*(n_q[4:0] - 5'd1) +: 4];
    oct0     = (conv_q == iff_pkg::CONV_OCT) && req_q.alternate_flag && zf == 7'd0 &&
               (nd == 7'd0 || top_dig != 4'd0);
    sgn      = 1'b0;
    sgn_ch   = iff_pkg::CH_SPACE;
    if (conv_q == iff_pkg::CONV_SDEC) begin
      if (req_q.is_negative) begin
        sgn = 1'b1; sgn_ch = iff_pkg::CH_MINUS;
      end else if (req_q.plus_flag) begin
        sgn = 1'b1; sgn_ch = iff_pkg::CH_PLUS;
      end else if (req_q.space_flag) begin
        sgn = 1'b1;
      end
    end
    pfx = 2'd0;
    if (conv_q == iff_pkg::CONV_PTR) pfx = 2'd2;
    else if (req_q.alternate_flag && !mag_zero &&
             (conv_q == iff_pkg::CONV_HEXL || conv_q == iff_pkg::CONV_HEXU)) pfx = 2'd2;
    fl = 8'(sgn) + 8'(pfx) + 8'(oct0) + 8'(zf) + 8'(nd);
  end

  logic [7:0] pfx_end;  // sign and prefix length
  logic [7:0] total;
  logic       zp;
  assign pfx_end = 8'(sign_q) + 8'(pfx_q);
  assign zp      = req_q.zero_flag && !req_q.left_flag && req_q.min_digits[6];
  assign total   = fl_q + pad_q;

  // Character at field index j.
  function automatic logic [7:0] field_char(input logic [7:0] j,
      input logic s, input logic [7:0] sc, input logic [1:0] p,
      input logic [7:0] xc, input logic [6:0] z, input logic [6:0] d,
      input logic [87:0] r, input logic up);
    logic [7:0] c;
    logic [7:0] o;
    logic [7:0] di;
    c = iff_pkg::CH_ZERO;
    o = j;
    if (s && o == 8'd0) c = sc;
    else begin
      if (s) o = o - 8'd1;
      if (p == 2'd2 && o == 8'd1) c = xc;
      else if (o < 8'(p)) c = iff_pkg::CH_ZERO;
      else begin
        o = o - 8'(p);
        if (o < 8'(z)) c = iff_pkg::CH_ZERO;
        else begin
          di = 8'(d) - 8'd1 - (o - 8'(z));
          c  = iff_pkg::digit_char(r[4*di[4:0] +: 4], up);
        end
      end
    end
    return c;
  endfunction

  logic [7:0] fidx;
  logic       is_pad;
  logic [7:0] ch;
  always_comb begin
    is_pad = 1'b0;
    fidx   = pos_q;
    if (req_q.left_flag) begin
      is_pad = pos_q >= fl_q;
    end else if (zp && pad_q != 8'd0) begin
      if (pos_q >= pfx_end && pos_q < pfx_end + pad_q) is_pad = 1'b1;
      else if (pos_q >= pfx_end) fidx = pos_q - pad_q;
    end else begin
      is_pad = pos_q < pad_q;
      fidx   = pos_q - pad_q;
    end
    if (is_pad) ch = (zp && !req_q.left_flag) ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
    else ch = field_char(fidx, sign_q, sign_ch_q, pfx_q, pfx1_ch_q, zf_q, nd_q,
                         revd_q, conv_q == iff_pkg::CONV_HEXU);
  end

  assign rsp_o.out_char  = ch;
  assign rsp_o.last_char = (pos_q + 8'd1 == total) || (k_q == CW'(MAX_CHARS - 1));
  assign sts_o.div_done  = div_done;
  assign sts_o.empty     = (total == 8'd0);
  assign sts_o.emit_last = rsp_o.last_char;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i;
      v_q    <= req_i.magnitude;
      n_q    <= 7'd0;
      ph_q   <= 2'd0;
      conv_q <= (req_i.conversion > iff_pkg::CONV_PTR) ? iff_pkg::CONV_UDEC
                                                      : req_i.conversion;
    end else if (cmd_i.div_step) begin
      if (commit) begin
        v_q                     <= quo;
        revd_q[4*n_q[4:0] +: 4] <= rem;
        n_q                     <= n_q + 7'd1;
        ph_q                    <= 2'd0;
      end else begin
        ph_q <= ph_q + 2'd1;
        case (ph_q)
          2'd0:    t_q <= a1;
          2'd1:    t_q <= b1;
          default: t_q <= c0;
        endcase
      end
    end
    if (cmd_i.plan) begin
      sign_q    <= sgn;
      sign_ch_q <= sgn_ch;
      pfx_q     <= pfx;
      pfx1_ch_q <= upper ? iff_pkg::CH_UX : iff_pkg::CH_LX;
      nd_q      <= nd;
      zf_q      <= zf + 7'(oct0);
      fl_q      <= fl;
      pad_q     <= ({1'b0, req_q.field_width} > fl) ? {1'b0, req_q.field_width} - fl : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      k_q   <= '0;
    end else if (cmd_i.plan) begin
      pos_q <= '0;
      k_q   <= '0;
    end else if (cmd_i.emit) begin
      pos_q <= pos_q + 8'd1;
      k_q   <= k_q + CW'(1);
    end
  end

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (k_q < CW'(MAX_CHARS))) else $error("overlong field");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (pos_q == $past(pos_q) + 8'd1)) else $error("position skip");
  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.plan |-> (n_q != 7'd0)) else $error("no digit produced");
endmodule
`default_nettype wire
